// ===== sv/assert_macros.svh =====
// Assertion macros for the checker file of the replacement block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising edge outside reset.
`define DRRP_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Property checked on every rising edge, reset included.
`define DRRP_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== sv/drrp_pkg.sv =====
// Shared constants, request and insertion types for the DRRIP replacement block.
package drrp_pkg;

  localparam int DRRP_NUM_SETS       = 2048;
  localparam int DRRP_NUM_WAYS       = 16;
  localparam int DRRP_SELECTOR_BITS  = 10;
  localparam int DRRP_SAMPLE_SPACING = 64;

  localparam int SET_IN_W = 11;
  localparam int WAY_IN_W = 4;
  localparam int VICTIM_W = 4;
  localparam int RRPV_W   = 2;
  localparam int FILL_W   = 5;

  localparam logic [RRPV_W-1:0] RRPV_MAX  = 2'd3;
  localparam logic [RRPV_W-1:0] RRPV_LONG = 2'd2;
  localparam logic [RRPV_W-1:0] RRPV_NEAR = 2'd0;

  localparam logic OP_FIND   = 1'b0;
  localparam logic OP_UPDATE = 1'b1;

  typedef struct packed {
    logic                op;
    logic [WAY_IN_W-1:0] way;
    logic                hit;
  } drrp_req_t;

  typedef struct packed {
    logic [RRPV_W-1:0] rrpv;
    logic              srrip;
  } drrp_ins_t;

  // Remainder of a set number by a constant modulus m: multiply by the
  // rounded-up reciprocal rcp = 2^sh / m, shift to get the quotient, then
  // multiply back and subtract. With sh = SET_IN_W + clog2(m) the quotient
  // is exact over the whole set number range.
  function automatic logic [SET_IN_W-1:0] drrp_mod(input logic [SET_IN_W-1:0] v,
                                                   input int unsigned m,
                                                   input int unsigned rcp,
                                                   input int unsigned sh);
    int unsigned q;
    q = (32'(v) * rcp) >> sh;
    return SET_IN_W'(32'(v) - q * m);
  endfunction

endpackage

// ===== sv/drrp_row_ram.sv =====
// Single-port-write, registered-read memory holding one packed RRPV row per set.
module drrp_row_ram
  import drrp_pkg::*;
#(
  parameter int DEPTH = DRRP_NUM_SETS,
  parameter int WIDTH = RRPV_W * DRRP_NUM_WAYS
) (
  input  logic                     clk,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== sv/drrp_row_update.sv =====
// Row modify logic: ages a set for a victim search or writes one way's RRPV.
module drrp_row_update
  import drrp_pkg::*;
#(
  parameter int NUM_WAYS = DRRP_NUM_WAYS
) (
  input  logic [RRPV_W*NUM_WAYS-1:0]    row,
  input  drrp_req_t                     req,
  input  drrp_ins_t                     ins,
  output logic [RRPV_W*NUM_WAYS-1:0]    row_new,
  output logic [$clog2(NUM_WAYS)-1:0]   victim
);

  localparam int WAY_W = $clog2(NUM_WAYS);

  logic [NUM_WAYS-1:0] is3, is2, is1, match;
  logic [RRPV_W-1:0]   top;
  logic [RRPV_W-1:0]   add;

  always_comb begin
    for (int w = 0; w < NUM_WAYS; w++) begin
      is3[w] = (row[RRPV_W*w +: RRPV_W] == 2'd3);
      is2[w] = (row[RRPV_W*w +: RRPV_W] == 2'd2);
      is1[w] = (row[RRPV_W*w +: RRPV_W] == 2'd1);
    end
    priority if (|is3) begin
      top = 2'd3;
    end else if (|is2) begin
      top = 2'd2;
    end else if (|is1) begin
      top = 2'd1;
    end else begin
      top = 2'd0;
    end
    add = RRPV_MAX - top;

    // Ways at the set's maximum reach 3 after aging; take the lowest one.
    for (int w = 0; w < NUM_WAYS; w++) begin
      match[w] = (row[RRPV_W*w +: RRPV_W] == top);
    end
    victim = '0;
    for (int w = NUM_WAYS - 1; w >= 0; w--) begin
      if (match[w]) begin
        victim = WAY_W'(w);
      end
    end

    row_new = row;
    if (req.op == OP_FIND) begin
      for (int w = 0; w < NUM_WAYS; w++) begin
        row_new[RRPV_W*w +: RRPV_W] = row[RRPV_W*w +: RRPV_W] + add;
      end
    end else begin
      // A way number past the set's width matches nothing: row stays intact.
      for (int w = 0; w < NUM_WAYS; w++) begin
        if (int'(req.way) == w) begin
          row_new[RRPV_W*w +: RRPV_W] = ins.rrpv;
        end
      end
    end
  end

endmodule

// ===== sv/drrp_policy.sv =====
// Set dueling: policy selector, bimodal fill counter and insertion choice.
module drrp_policy
  import drrp_pkg::*;
#(
  parameter int SELECTOR_BITS  = DRRP_SELECTOR_BITS,
  parameter int SAMPLE_SPACING = DRRP_SAMPLE_SPACING
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                fire,
  input  logic [SET_IN_W-1:0] set_idx,
  input  logic                hit,
  output drrp_ins_t           ins
);

  localparam logic [SELECTOR_BITS-1:0] SEL_MAX  = {SELECTOR_BITS{1'b1}};
  localparam logic [SELECTOR_BITS-1:0] SEL_INIT = SEL_MAX >> 1;
  localparam int unsigned SPC_SH  = SET_IN_W + $clog2(SAMPLE_SPACING);
  localparam int unsigned SPC_RCP =
    32'(((64'd1 << SPC_SH) + SAMPLE_SPACING - 1) / SAMPLE_SPACING);

  logic [SELECTOR_BITS-1:0] sel;
  logic [FILL_W-1:0]        fill_cnt;
  logic [SET_IN_W-1:0]      rem;
  logic                     in_srrip_group, in_brrip_group, use_s;

  always_comb begin
    rem            = drrp_mod(set_idx, SAMPLE_SPACING, SPC_RCP, SPC_SH);
    in_srrip_group = (rem == SET_IN_W'(0));
    in_brrip_group = (rem == SET_IN_W'(1));
    use_s = in_srrip_group || (!in_brrip_group && (sel >= SEL_INIT));
    if (hit) begin
      ins.rrpv  = RRPV_NEAR;
      ins.srrip = 1'b0;
    end else if (use_s) begin
      ins.rrpv  = RRPV_LONG;
      ins.srrip = 1'b1;
    end else begin
      // Every 32nd bimodal fill lands at long instead of distant.
      ins.rrpv  = (fill_cnt == '1) ? RRPV_LONG : RRPV_MAX;
      ins.srrip = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sel      <= SEL_INIT;
      fill_cnt <= '0;
    end else if (fire) begin
      if (hit) begin
        if (in_srrip_group && (sel != SEL_MAX)) begin
          sel <= sel + 1'b1;
        end else if (in_brrip_group && (sel != '0)) begin
          sel <= sel - 1'b1;
        end
      end else if (!use_s) begin
        fill_cnt <= fill_cnt + 1'b1;
      end
    end
  end

endmodule

// ===== sv/drrip_replacement_policy_core.sv =====
// Top level of the DRRIP replacement state block: control, row memory and policy.
//
// Command interface. Drive opcode, set_index, way and hit with start high; the
// word is taken at a rising edge where start is high and busy is low.
// opcode find ages the set until some way holds 3 and returns the lowest such
// way on victim_way; opcode update writes 0 (hit) or the insertion value
// (miss fill) to the way, reports it on new_rrpv and, for a fill that used
// SRRIP insertion, raises chose_srrip.
// Every command yields one result word, shown for one cycle with done high.
// The result registers and done load at the edge that ends the modify state.
// A new command waits until the last is through: the set's packed row is read from
// the row memory at the accept edge, modified and written back at the next
// edge, and busy holds off the next command until that write has landed, so
// a command to the same set always sees the previous result.
// Reset: the row memory is swept to all-3 rows, one set per cycle, with busy
// high until the last set is written; the selector returns to its midpoint
// and the fill counter to 0.
// The receiver cannot stall: done is a strobe and the result is never held.
module drrip_replacement_policy_core
  import drrp_pkg::*;
#(
  parameter int NUM_SETS       = DRRP_NUM_SETS,
  parameter int NUM_WAYS       = DRRP_NUM_WAYS,
  parameter int SELECTOR_BITS  = DRRP_SELECTOR_BITS,
  parameter int SAMPLE_SPACING = DRRP_SAMPLE_SPACING
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  logic                opcode,
  input  logic [SET_IN_W-1:0] set_index,
  input  logic [WAY_IN_W-1:0] way,
  input  logic                hit,
  output logic                done,
  output logic [VICTIM_W-1:0] victim_way,
  output logic [RRPV_W-1:0]   new_rrpv,
  output logic                chose_srrip
);

  localparam int SET_W = $clog2(NUM_SETS);
  localparam int WAY_W = $clog2(NUM_WAYS);
  localparam int ROW_W = RRPV_W * NUM_WAYS;
  localparam logic [SET_W-1:0] LAST_SET = SET_W'(NUM_SETS - 1);
  localparam int unsigned SET_MOD_SH  = SET_IN_W + $clog2(NUM_SETS);
  localparam int unsigned SET_MOD_RCP =
    32'(((64'd1 << SET_MOD_SH) + NUM_SETS - 1) / NUM_SETS);

  typedef enum logic [2:0] {
    ST_CLEAR = 3'b001,
    ST_IDLE  = 3'b010,
    ST_EXEC  = 3'b100
  } state_t;

  state_t              state, state_next;
  logic [SET_W-1:0]    clr_cnt;
  logic                accept;
  logic [SET_IN_W-1:0] set_red;
  drrp_req_t           req;
  logic [SET_IN_W-1:0] set_q;

  logic                rd_en, wr_en;
  logic [SET_W-1:0]    wr_addr;
  logic [ROW_W-1:0]    rd_row, wr_row, row_new;
  logic [WAY_W-1:0]    victim;
  drrp_ins_t           ins;

  assign busy   = (state != ST_IDLE);
  assign accept = start && !busy;

  // Fold the set number into the table depth.
  assign set_red = drrp_mod(set_index, NUM_SETS, SET_MOD_RCP, SET_MOD_SH);
  assign rd_en   = accept;

  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR: begin
        if (clr_cnt == LAST_SET) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          state_next = ST_EXEC;
        end
      end
      ST_EXEC: begin
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_CLEAR;
      clr_cnt <= '0;
    end else begin
      state <= state_next;
      if (state == ST_CLEAR) begin
        clr_cnt <= clr_cnt + 1'b1;
      end
    end
  end

  // Hold the command for the modify cycle.
  always_ff @(posedge clk) begin
    if (accept) begin
      req.op  <= opcode;
      req.way <= way;
      req.hit <= hit;
      set_q   <= set_red;
    end
  end

  // Write port: clearing sweep after reset, write-back of the modified row otherwise.
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = SET_W'(set_q);
    wr_row  = row_new;
    if (state == ST_CLEAR) begin
      wr_en   = 1'b1;
      wr_addr = clr_cnt;
      wr_row  = '1;
    end else if (state == ST_EXEC) begin
      wr_en = 1'b1;
    end
  end

  drrp_row_ram #(
    .DEPTH (NUM_SETS),
    .WIDTH (ROW_W)
  ) u_ram (
    .clk     (clk),
    .rd_en   (rd_en),
    .rd_addr (SET_W'(set_red)),
    .rd_data (rd_row),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_row)
  );

  drrp_row_update #(
    .NUM_WAYS (NUM_WAYS)
  ) u_upd (
    .row     (rd_row),
    .req     (req),
    .ins     (ins),
    .row_new (row_new),
    .victim  (victim)
  );

  drrp_policy #(
    .SELECTOR_BITS  (SELECTOR_BITS),
    .SAMPLE_SPACING (SAMPLE_SPACING)
  ) u_pol (
    .clk     (clk),
    .rst     (rst),
    .fire    ((state == ST_EXEC) && (req.op == OP_UPDATE)),
    .set_idx (set_q),
    .hit     (req.hit),
    .ins     (ins)
  );

  // Result word: strobe for one cycle after the modify cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= (state == ST_EXEC);
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_EXEC) begin
      if (req.op == OP_FIND) begin
        victim_way  <= VICTIM_W'(victim);
        new_rrpv    <= RRPV_NEAR;
        chose_srrip <= 1'b0;
      end else begin
        victim_way  <= '0;
        new_rrpv    <= ins.rrpv;
        chose_srrip <= ins.srrip;
      end
    end
  end

endmodule

// ===== sv/drrp_checker.sv =====
// Port-level checker for the DRRIP replacement block, bound to the top level.
`include "assert_macros.svh"

module drrp_checker (
  input logic clk,
  input logic rst,
  input logic start,
  input logic busy,
  input logic done
);

  `DRRP_ASSERT_ALWAYS(a_reset_sweep, rst |=> (busy && !done), "no sweep after reset")
  `DRRP_ASSERT(a_accept_busy, (start && !busy) |=> (busy && !done), "command not held busy")
  `DRRP_ASSERT(a_result_two, (start && !busy) |=> ##1 done, "result not after two edges")
  `DRRP_ASSERT(a_done_single, done |=> !done, "result strobe longer than one cycle")
  `DRRP_ASSERT(a_done_idle, done |-> !busy, "result shown while busy")

endmodule

bind drrip_replacement_policy_core drrp_checker u_chk (.*);
